// ===== hdl/ppr_pkg.sv =====
// Package for the payload pattern replacer: sizes, FSM state type, control
// structs and the default pattern bytes that the cell row resets to.
// No dependencies.
`default_nettype none

package ppr_pkg;

   // Sizes
   localparam int MAX_PATTERN = 32;
   localparam int BURST_LIMIT = 32;
   localparam int NCELL       = (MAX_PATTERN < BURST_LIMIT) ? MAX_PATTERN : BURST_LIMIT;
   localparam int POS_W       = $clog2(NCELL);
   localparam int LEN_W       = 6;
   localparam int IDX_W       = 5;
   localparam int BYTE_W      = 8;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(NCELL);

   // Request kinds
   localparam logic REQ_PAYLOAD   = 1'b0;
   localparam logic REQ_TBL_WRITE = 1'b1;

   // Configuration register indexes
   localparam logic CSR_OUT_LEN = 1'b0;
   localparam logic CSR_IN_LEN  = 1'b1;

   // Reset values of the length registers
   localparam logic [LEN_W-1:0] OUT_LEN_RST = 6'd22;
   localparam logic [LEN_W-1:0] IN_LEN_RST  = 6'd7;

   // Default outbound search/replace pair (22 bytes)
   localparam int OUT_DFLT_LEN = 22;
   localparam logic [7:0] OUT_FIND_DFLT [OUT_DFLT_LEN] = '{
      8'h41, 8'h63, 8'h63, 8'h65, 8'h70, 8'h74, 8'h2D, 8'h45, 8'h6E, 8'h63, 8'h6F,
      8'h64, 8'h69, 8'h6E, 8'h67, 8'h3A, 8'h20, 8'h67, 8'h7A, 8'h69, 8'h70, 8'h2C};
   localparam logic [7:0] OUT_PUT_DFLT [OUT_DFLT_LEN] = '{
      8'h41, 8'h63, 8'h63, 8'h65, 8'h70, 8'h74, 8'h2D, 8'h45, 8'h6E, 8'h63, 8'h6F,
      8'h64, 8'h69, 8'h6E, 8'h67, 8'h3A, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20};

   // Default inbound search/replace pair (7 bytes)
   localparam int IN_DFLT_LEN = 7;
   localparam logic [7:0] IN_FIND_DFLT [IN_DFLT_LEN] = '{
      8'h4D, 8'h69, 8'h63, 8'h68, 8'h61, 8'h65, 8'h6C};
   localparam logic [7:0] IN_PUT_DFLT [IN_DFLT_LEN] = '{
      8'h47, 8'h69, 8'h6C, 8'h62, 8'h65, 8'h72, 8'h74};

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_CHECK,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   // Row-wide control from the sequencer
   typedef struct packed {
      logic              shift;
      logic              push;
      logic              apply;
      logic              write;
      logic              dir;
      logic [POS_W-1:0]  push_pos;
      logic [IDX_W-1:0]  wr_pos;
      logic [LEN_W-1:0]  len;
   } chain_ctrl_type;

   // Per-cell control
   typedef struct packed {
      logic shift;
      logic load;
      logic apply;
      logic write;
      logic dir;
   } cell_ctrl_type;

   // Default search byte of a position for one direction
   function automatic logic [7:0] dflt_search(input logic dir, input int unsigned pos);
      logic [7:0] val;
      val = 8'h00;
      if (!dir && pos < OUT_DFLT_LEN) val = OUT_FIND_DFLT[pos];
      if (dir && pos < IN_DFLT_LEN)   val = IN_FIND_DFLT[pos];
      return val;
   endfunction

   // Default replacement byte of a position for one direction
   function automatic logic [7:0] dflt_replace(input logic dir, input int unsigned pos);
      logic [7:0] val;
      val = 8'h00;
      if (!dir && pos < OUT_DFLT_LEN) val = OUT_PUT_DFLT[pos];
      if (dir && pos < IN_DFLT_LEN)   val = IN_PUT_DFLT[pos];
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ppr_if.sv =====
// Channel interfaces of the payload pattern replacer: request, response and
// configuration write. Depends on ppr_pkg.
`default_nettype none

interface ppr_req_if import ppr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic              direction;
   logic [BYTE_W-1:0] data_byte;
   logic              is_last;
   logic [IDX_W-1:0]  table_index;
   logic [BYTE_W-1:0] replace_byte;

   modport source (output valid, req_type, direction, data_byte, is_last, table_index,
                   replace_byte, input ready);
   modport sink   (input valid, req_type, direction, data_byte, is_last, table_index,
                   replace_byte, output ready);
endinterface

interface ppr_rsp_if import ppr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_last;
   logic              was_replaced;

   modport source (output valid, out_byte, out_last, was_replaced, input ready);
   modport sink   (input valid, out_byte, out_last, was_replaced, output ready);
endinterface

interface ppr_csr_if import ppr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             reg_index;
   logic [LEN_W-1:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ppr_cell.sv =====
// One cell of the pattern row: a window byte plus the search and replace
// bytes of its position for both directions. Depends on ppr_pkg.
`default_nettype none

module ppr_cell import ppr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_ctrl_type          ctrl,
   input  logic [BYTE_W-1:0]      shift_in,
   input  logic [BYTE_W-1:0]      push_byte,
   input  logic [BYTE_W-1:0]      wr_search,
   input  logic [BYTE_W-1:0]      wr_replace,
   input  logic [1:0][BYTE_W-1:0] rst_search,
   input  logic [1:0][BYTE_W-1:0] rst_replace,
   output logic [BYTE_W-1:0]      win_byte,
   output logic                   hit
);

   logic [BYTE_W-1:0]      win_ff, win_in;
   logic [1:0][BYTE_W-1:0] srch_ff, srch_in;
   logic [1:0][BYTE_W-1:0] repl_ff, repl_in;

   // Window byte: replacement wins over shift, shift over push
   always_comb begin
      win_in = win_ff;
      if (ctrl.apply) begin
         win_in = repl_ff[ctrl.dir];
      end else if (ctrl.shift) begin
         win_in = shift_in;
      end else if (ctrl.load) begin
         win_in = push_byte;
      end
   end

   // Pattern bytes of this position
   always_comb begin
      srch_in = srch_ff;
      repl_in = repl_ff;
      if (ctrl.write) begin
         srch_in[ctrl.dir] = wr_search;
         repl_in[ctrl.dir] = wr_replace;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srch_ff <= rst_search;
         repl_ff <= rst_replace;
      end else begin
         srch_ff <= srch_in;
         repl_ff <= repl_in;
      end
   end

   assign win_byte = win_ff;
   assign hit      = (win_ff == srch_ff[ctrl.dir]);

endmodule

`default_nettype wire

// ===== hdl/ppr_chain.sv =====
// Row of pattern cells: window shift toward the head, per-position writes and
// the match reduction over the active length. Depends on ppr_pkg, ppr_cell.
`default_nettype none

module ppr_chain import ppr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  chain_ctrl_type    ctrl,
   input  logic [BYTE_W-1:0] push_byte,
   input  logic [BYTE_W-1:0] wr_search,
   input  logic [BYTE_W-1:0] wr_replace,
   output logic [BYTE_W-1:0] head_byte,
   output logic              match
);

   logic [BYTE_W-1:0] win      [NCELL];
   logic [BYTE_W-1:0] shift_in [NCELL];
   logic [NCELL-1:0]  hit;
   logic [NCELL-1:0]  hit_en;
   cell_ctrl_type     cc       [NCELL];

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      logic in_len;
      assign in_len = (LEN_W'(i) < ctrl.len);

      // Decode row control for this position
      assign cc[i] = '{shift: ctrl.shift,
                       load:  ctrl.push && (ctrl.push_pos == POS_W'(i)),
                       apply: ctrl.apply && in_len,
                       write: ctrl.write && (ctrl.wr_pos == IDX_W'(i)),
                       dir:   ctrl.dir};

      // Neighbor feed; the tail takes zero
      if (i == NCELL - 1) begin : g_tail
         assign shift_in[i] = '0;
      end else begin : g_mid
         assign shift_in[i] = win[i+1];
      end

      assign hit_en[i] = hit[i] || !in_len;

      ppr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cc[i]),
         .shift_in    (shift_in[i]),
         .push_byte   (push_byte),
         .wr_search   (wr_search),
         .wr_replace  (wr_replace),
         .rst_search  ({dflt_search(1'b1, i), dflt_search(1'b0, i)}),
         .rst_replace ({dflt_replace(1'b1, i), dflt_replace(1'b0, i)}),
         .win_byte    (win[i]),
         .hit         (hit[i])
      );
   end

   assign head_byte = win[0];
   assign match     = &hit_en;

endmodule

`default_nettype wire

// ===== hdl/payload_pattern_replace_top.sv =====
// Top level of the payload pattern replacer: length registers, sequencer and
// response register around the cell row. Depends on ppr_pkg, ppr_if, ppr_chain.
//
//   channel  dir  handshake      carries
//   req_ch   in   valid/ready    req_type, direction, data_byte, is_last,
//                                table_index, replace_byte
//   rsp_ch   out  valid/ready    out_byte, out_last, was_replaced
//   csr_ch   in   valid/ready    reg_index (0 outbound len, 1 inbound len), wr_data
//
// A table write is taken in the idle state. A payload byte that releases one byte passes
// through accept, drain/push, compare and emit; while the window is still filling it
// skips emit, and with search off it leaves from drain. Held bytes are pushed out
// first when the length shrinks or search is off. A byte with is_last goes from
// compare to a flush that sends every held byte, the last one marked out_last.
// Reset is synchronous; it loads the default patterns and empties the window.
// A stalled response holds the sequencer in place; req_ch.ready is high only
// while idle, csr_ch.ready always.
`default_nettype none

module payload_pattern_replace_top import ppr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   ppr_req_if.sink  req_ch,
   ppr_rsp_if.source rsp_ch,
   ppr_csr_if.sink  csr_ch
);

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic [LEN_W-1:0]  in_len_ff, in_len_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              dir_ff, dir_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic              match_done_ff, match_done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_repl_ff, rsp_repl_in;

   chain_ctrl_type    ctrl;
   logic [BYTE_W-1:0] head_byte;
   logic              match;
   logic              out_free;
   logic              emit;
   logic [LEN_W-1:0]  raw_len;

   // Configuration writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      out_len_in = out_len_ff;
      in_len_in  = in_len_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            CSR_OUT_LEN: out_len_in = csr_ch.wr_data;
            CSR_IN_LEN:  in_len_in  = csr_ch.wr_data;
            default:     ;
         endcase
      end
   end

   // Effective length of the incoming item's direction
   assign raw_len = req_ch.direction ? in_len_ff : out_len_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      dir_in        = dir_ff;
      len_in        = len_ff;
      fill_in       = fill_ff;
      match_done_in = match_done_ff;
      emit          = 1'b0;
      rsp_byte_in   = head_byte;
      rsp_last_in   = 1'b0;
      rsp_repl_in   = 1'b0;
      req_ch.ready  = 1'b0;

      ctrl          = '0;
      ctrl.dir      = dir_ff;
      ctrl.len      = len_ff;
      ctrl.push_pos = fill_ff[POS_W-1:0];
      ctrl.wr_pos   = req_ch.table_index;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            ctrl.dir     = req_ch.direction;
            if (req_ch.valid) begin
               if (req_ch.req_type == REQ_TBL_WRITE) begin
                  ctrl.write = 1'b1;
               end else begin
                  byte_in  = req_ch.data_byte;
                  last_in  = req_ch.is_last;
                  dir_in   = req_ch.direction;
                  len_in   = (raw_len > LEN_MAX) ? LEN_MAX : raw_len;
                  state_in = ST_DRAIN;
               end
            end
         end

         ST_DRAIN: begin
            if (fill_ff != '0 && fill_ff >= len_ff) begin
               // Oldest held bytes leave until the new byte fits
               if (out_free) begin
                  emit       = 1'b1;
                  ctrl.shift = 1'b1;
                  fill_in    = fill_ff - LEN_W'(1);
               end
            end else if (len_ff == '0) begin
               // Search off: byte goes straight out
               if (out_free) begin
                  emit        = 1'b1;
                  rsp_byte_in = byte_ff;
                  rsp_last_in = last_ff;
                  rsp_repl_in = last_ff && match_done_ff;
                  if (last_ff) begin
                     match_done_in = 1'b0;
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               ctrl.push = 1'b1;
               fill_in   = fill_ff + LEN_W'(1);
               state_in  = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (fill_ff == len_ff && !match_done_ff && match) begin
               ctrl.apply    = 1'b1;
               match_done_in = 1'b1;
            end
            if (last_ff) begin
               state_in = ST_FLUSH;
            end else if (fill_ff == len_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               emit       = 1'b1;
               ctrl.shift = 1'b1;
               fill_in    = fill_ff - LEN_W'(1);
               state_in   = ST_IDLE;
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               emit        = 1'b1;
               ctrl.shift  = 1'b1;
               fill_in     = fill_ff - LEN_W'(1);
               rsp_last_in = (fill_ff == LEN_W'(1));
               rsp_repl_in = (fill_ff == LEN_W'(1)) && match_done_ff;
               if (fill_ff == LEN_W'(1)) begin
                  match_done_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_len_ff    <= OUT_LEN_RST;
         in_len_ff     <= IN_LEN_RST;
         fill_ff       <= '0;
         match_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         out_len_ff    <= out_len_in;
         in_len_ff     <= in_len_in;
         fill_ff       <= fill_in;
         match_done_ff <= match_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Item and response payload
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      dir_ff  <= dir_in;
      len_ff  <= len_in;
      if (emit) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
         rsp_repl_ff <= rsp_repl_in;
      end
   end

   ppr_chain u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .push_byte  (byte_ff),
      .wr_search  (req_ch.data_byte),
      .wr_replace (req_ch.replace_byte),
      .head_byte  (head_byte),
      .match      (match)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_byte     = rsp_byte_ff;
   assign rsp_ch.out_last     = rsp_last_ff;
   assign rsp_ch.was_replaced = rsp_repl_ff;

endmodule

`default_nettype wire

// ===== hdl/ppr_checker.sv =====
// Port-level checks of the payload pattern replacer and the bind that
// attaches them to payload_pattern_replace_top. Depends on ppr_pkg.
`default_nettype none

module ppr_checker import ppr_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_type,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_byte,
   input logic              rsp_last,
   input logic              rsp_repl
);

   // A stalled response keeps its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last)
                                  && $stable(rsp_repl))
      else $error("response changed while stalled");

   // Replacement flag only rides on the final byte
   a_repl_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_repl |-> rsp_last)
      else $error("was_replaced without out_last");

   // A payload byte occupies the block for the next cycle
   a_busy_after_byte: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_PAYLOAD |=> !req_ready)
      else $error("ready right after payload byte");

   // A table write completes in its own cycle
   a_tbl_write_1cyc: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_TBL_WRITE |=> req_ready)
      else $error("table write stalled the request channel");

   // Nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind payload_pattern_replace_top ppr_checker u_ppr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_type  (req_ch.req_type),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_byte  (rsp_ch.out_byte),
   .rsp_last  (rsp_ch.out_last),
   .rsp_repl  (rsp_ch.was_replaced)
);

`default_nettype wire

// ===== dv/tb_payload_pattern_replace_top.sv =====
// Self-checking testbench for payload_pattern_replace_top: drives payload bytes and
// table writes, predicts the replaced byte stream and checks every response.
// Depends on ppr_pkg, ppr_if and the RTL top level.
`default_nettype none

module tb_payload_pattern_replace_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ppr_pkg::*;

   // Default patterns after reset, first byte in the top bits
   localparam logic [22*8-1:0] OUT_FIND_STR = "Accept-Encoding: gzip,";
   localparam logic [22*8-1:0] OUT_PUT_STR  = "Accept-Encoding:      ";
   localparam logic [7*8-1:0]  IN_FIND_STR  = 56'h4D_69_63_68_61_65_6C;
   localparam logic [7*8-1:0]  IN_PUT_STR   = 56'h47_69_6C_62_65_72_74;
   localparam int TBL_DEPTH  = 2 * MAX_PATTERN;
   localparam int NUM_PHASES = 6;
   localparam int QUIET_WAIT = 12;
   localparam int END_WAIT   = 40;

   typedef struct packed {
      logic              req_type;
      logic              direction;
      logic [BYTE_W-1:0] data_byte;
      logic              is_last;
      logic [IDX_W-1:0]  table_index;
      logic [BYTE_W-1:0] replace_byte;
      logic              hold;          // wait for all responses before sending
   } req_item_type;

   typedef struct packed {
      logic              reg_index;
      logic [LEN_W-1:0]  wr_data;
   } len_write_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_last;
      logic              was_replaced;
   } out_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ppr_req_if req_ch ();
   ppr_rsp_if rsp_ch ();
   ppr_csr_if csr_ch ();

   // Driven copies of the block inputs
   logic          req_valid = 1'b0;
   req_item_type  cur_req   = '0;
   logic          rsp_ready = 1'b0;
   logic          csr_valid = 1'b0;
   len_write_type cur_len_wr = '0;

   assign req_ch.valid        = req_valid;
   assign req_ch.req_type     = cur_req.req_type;
   assign req_ch.direction    = cur_req.direction;
   assign req_ch.data_byte    = cur_req.data_byte;
   assign req_ch.is_last      = cur_req.is_last;
   assign req_ch.table_index  = cur_req.table_index;
   assign req_ch.replace_byte = cur_req.replace_byte;
   assign rsp_ch.ready        = rsp_ready;
   assign csr_ch.valid        = csr_valid;
   assign csr_ch.reg_index    = cur_len_wr.reg_index;
   assign csr_ch.wr_data      = cur_len_wr.wr_data;

   payload_pattern_replace_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // Stimulus and expectation queues, idle rates of the current phase
   req_item_type  pending_reqs [$];
   len_write_type pending_len_wr [$];
   out_byte_type  expected_bytes [$];
   int            send_gap_pct  = 0;
   int            rsp_stall_pct = 0;
   int            error_count   = 0;

   // Replacer model state
   logic [BYTE_W-1:0] find_mem [0:TBL_DEPTH-1];
   logic [BYTE_W-1:0] put_mem  [0:TBL_DEPTH-1];
   logic [BYTE_W-1:0] win      [0:MAX_PATTERN-1];
   int unsigned       win_fill;
   bit                hit_done;
   logic [LEN_W-1:0]  len_reg  [0:1];

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [7:0] dflt_byte(input bit put, input logic dir,
                                            input int unsigned pos);
      logic [7:0] val;
      val = 8'h00;
      if (!dir && pos < 22)
         val = put ? OUT_PUT_STR[(21-pos)*8 +: 8] : OUT_FIND_STR[(21-pos)*8 +: 8];
      if (dir && pos < 7)
         val = put ? IN_PUT_STR[(6-pos)*8 +: 8] : IN_FIND_STR[(6-pos)*8 +: 8];
      return val;
   endfunction

   // Length register clamped to the window size
   function automatic int unsigned eff_len(input logic dir);
      int unsigned l;
      l = dir ? len_reg[CSR_IN_LEN] : len_reg[CSR_OUT_LEN];
      if (l > MAX_PATTERN) l = MAX_PATTERN;
      if (l > BURST_LIMIT) l = BURST_LIMIT;
      return l;
   endfunction

   function automatic logic [7:0] pop_window();
      logic [7:0]  b;
      int unsigned i;
      b = win[0];
      for (i = 1; i < win_fill; i++) win[i-1] = win[i];
      win_fill--;
      return b;
   endfunction

   function automatic void queue_out_byte(input logic [7:0] b, input logic last);
      out_byte_type o;
      o.out_byte     = b;
      o.out_last     = last;
      o.was_replaced = last && hit_done;
      expected_bytes.push_back(o);
   endfunction

   // Apply one accepted transaction to the model and queue the bytes it releases
   task automatic predict_replace(input req_item_type it);
      int unsigned len, base, i;
      bit          eq;
      logic [7:0]  b;
      base = it.direction ? MAX_PATTERN : 0;
      if (it.req_type == REQ_TBL_WRITE) begin
         if (it.table_index < MAX_PATTERN) begin
            find_mem[base + it.table_index] = it.data_byte;
            put_mem[base + it.table_index]  = it.replace_byte;
         end
      end else begin
         len = eff_len(it.direction);
         if (len == 0) begin
            // search off: flush what is held, then pass the byte through
            while (win_fill > 0) queue_out_byte(pop_window(), 1'b0);
            queue_out_byte(it.data_byte, it.is_last);
            if (it.is_last) hit_done = 1'b0;
         end else begin
            while (win_fill > len - 1) queue_out_byte(pop_window(), 1'b0);
            win[win_fill] = it.data_byte;
            win_fill++;
            if (win_fill == len && !hit_done) begin
               eq = 1'b1;
               for (i = 0; i < len; i++)
                  if (win[i] != find_mem[base + i]) eq = 1'b0;
               if (eq) begin
                  for (i = 0; i < len; i++) win[i] = put_mem[base + i];
                  hit_done = 1'b1;
               end
            end
            if (it.is_last) begin
               while (win_fill > 0) begin
                  b = pop_window();
                  queue_out_byte(b, win_fill == 0);
               end
               hit_done = 1'b0;
            end else if (win_fill == len) begin
               queue_out_byte(pop_window(), 1'b0);
            end
         end
      end
   endtask

   // Driver: request and length-write channels, model updated on acceptance
   always @(posedge clock) begin : driver
      int i;
      if (reset) begin
         for (i = 0; i < TBL_DEPTH; i++) begin
            find_mem[i] = dflt_byte(1'b0, i >= MAX_PATTERN, i % MAX_PATTERN);
            put_mem[i]  = dflt_byte(1'b1, i >= MAX_PATTERN, i % MAX_PATTERN);
         end
         for (i = 0; i < MAX_PATTERN; i++) win[i] = 8'h00;
         win_fill = 0;
         hit_done = 1'b0;
         len_reg[CSR_OUT_LEN] = OUT_LEN_RST;
         len_reg[CSR_IN_LEN]  = IN_LEN_RST;
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (req_valid && req_ch.ready) predict_replace(cur_req);
         if (csr_valid && csr_ch.ready) len_reg[cur_len_wr.reg_index] = cur_len_wr.wr_data;

         if (!req_valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct &&
                !(pending_reqs[0].hold && expected_bytes.size() != 0)) begin
               cur_req   <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end

         if (!csr_valid || csr_ch.ready) begin
            if (pending_len_wr.size() != 0) begin
               cur_len_wr <= pending_len_wr.pop_front();
               csr_valid  <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response transaction with the oldest expected byte
   always @(posedge clock) begin : monitor
      out_byte_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_error($sformatf("unexpected response byte %02h", rsp_ch.out_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_ch.out_byte !== want.out_byte)
                  report_error($sformatf("out_byte %02h, want %02h",
                                         rsp_ch.out_byte, want.out_byte));
               if (rsp_ch.out_last !== want.out_last)
                  report_error($sformatf("out_last %b, want %b",
                                         rsp_ch.out_last, want.out_last));
               if (rsp_ch.was_replaced !== want.was_replaced)
                  report_error($sformatf("was_replaced %b, want %b",
                                         rsp_ch.was_replaced, want.was_replaced));
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Stimulus side: search bytes as they will stand once queued writes land
   logic [BYTE_W-1:0] gen_find [0:TBL_DEPTH-1];
   logic [LEN_W-1:0]  phase_out_len [0:NUM_PHASES-1] = '{6'd22, 6'd1, 6'd63, 6'd5, 6'd32, 6'd0};
   logic [LEN_W-1:0]  phase_in_len  [0:NUM_PHASES-1] = '{6'd7, 6'd32, 6'd0, 6'd3, 6'd40, 6'd12};

   function automatic req_item_type mk_req(input logic t, input logic dir,
                                           input logic [7:0] b, input logic last,
                                           input logic [4:0] idx, input logic [7:0] rb);
      req_item_type it;
      it.req_type     = t;
      it.direction    = dir;
      it.data_byte    = b;
      it.is_last      = last;
      it.table_index  = idx;
      it.replace_byte = rb;
      it.hold         = 1'b0;
      return it;
   endfunction

   // Wait until all transactions are sent and answered, then let the block settle
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_bytes.size() != 0);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   task automatic write_len(input logic idx, input logic [LEN_W-1:0] val);
      len_write_type w;
      w.reg_index = idx;
      w.wr_data   = val;
      pending_len_wr.push_back(w);
      do @(posedge clock);
      while (pending_len_wr.size() != 0 || csr_valid);
   endtask

   // One random packet, or a short burst of table writes
   task automatic gen_packet(input bit hold_first, output int count);
      req_item_type pkt [$];
      int unsigned  len, pick, pre, post, reps, bad_pos, base, i, r, k, idx;
      logic         dir;
      logic [7:0]   b;
      dir  = 1'($urandom_range(1));
      len  = eff_len(dir);
      base = dir ? MAX_PATTERN : 0;
      pick = $urandom_range(99);
      if (pick < 15) begin
         k = $urandom_range(1, 3);
         for (i = 0; i < k; i++) begin
            idx = (len != 0 && $urandom_range(3) != 0) ? $urandom_range(len - 1)
                                                       : $urandom_range(31);
            b = 8'($urandom_range(255));
            pkt.push_back(mk_req(REQ_TBL_WRITE, dir, b, 1'($urandom_range(1)), 5'(idx),
                                 8'($urandom_range(255))));
            gen_find[base + idx] = b;
         end
      end else begin
         pre  = $urandom_range(3);
         post = $urandom_range(3);
         reps = (len == 0 || pick < 30) ? 0 : ((pick < 40) ? 2 : 1);
         bad_pos = (len != 0 && $urandom_range(4) == 0) ? $urandom_range(len - 1) : len;
         for (i = 0; i < pre; i++)
            pkt.push_back(mk_req(REQ_PAYLOAD, dir, 8'($urandom_range(255)), 1'b0,
                                 5'($urandom_range(31)), 8'($urandom_range(255))));
         for (r = 0; r < reps; r++)
            for (i = 0; i < len; i++) begin
               b = gen_find[base + i];
               if (r == 0 && i == bad_pos) b = ~b;   // near miss
               pkt.push_back(mk_req(REQ_PAYLOAD, dir, b, 1'b0, 5'($urandom_range(31)),
                                    8'($urandom_range(255))));
            end
         for (i = 0; i < post; i++)
            pkt.push_back(mk_req(REQ_PAYLOAD, dir, 8'($urandom_range(255)), 1'b0,
                                 5'($urandom_range(31)), 8'($urandom_range(255))));
         if (pkt.size() == 0)
            pkt.push_back(mk_req(REQ_PAYLOAD, dir, 8'($urandom_range(255)), 1'b0,
                                 5'($urandom_range(31)), 8'($urandom_range(255))));
         // occasional byte of the other direction inside the packet
         if ($urandom_range(9) == 0) begin
            k = $urandom_range(pkt.size() - 1);
            pkt[k].direction = ~pkt[k].direction;
         end
         pkt[pkt.size() - 1].is_last = 1'b1;
      end
      pkt[0].hold = hold_first || ($urandom_range(99) < 8);
      count = pkt.size();
      foreach (pkt[i]) pending_reqs.push_back(pkt[i]);
   endtask

   initial begin : sequencer
      int i, ph, added, n;
      req_item_type it;
      for (i = 0; i < TBL_DEPTH; i++)
         gen_find[i] = dflt_byte(1'b0, i >= MAX_PATTERN, i % MAX_PATTERN);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: default inbound pattern after one byte of lead-in
      pending_reqs.push_back(mk_req(REQ_PAYLOAD, 1'b1, 8'h78, 1'b0, 5'd0, 8'h00));
      for (i = 0; i < 7; i++)
         pending_reqs.push_back(mk_req(REQ_PAYLOAD, 1'b1, dflt_byte(1'b0, 1'b1, i),
                                       i == 6, 5'd0, 8'h00));
      // Direction change inside a packet, flushed by last; sender waits for the
      // previous packet to drain completely first
      it = mk_req(REQ_PAYLOAD, 1'b0, dflt_byte(1'b0, 1'b0, 0), 1'b0, 5'd0, 8'h00);
      it.hold = 1'b1;
      pending_reqs.push_back(it);
      pending_reqs.push_back(mk_req(REQ_PAYLOAD, 1'b0, dflt_byte(1'b0, 1'b0, 1), 1'b0,
                                    5'd0, 8'h00));
      pending_reqs.push_back(mk_req(REQ_PAYLOAD, 1'b1, dflt_byte(1'b0, 1'b1, 0), 1'b0,
                                    5'd0, 8'h00));
      pending_reqs.push_back(mk_req(REQ_PAYLOAD, 1'b1, 8'h00, 1'b1, 5'd0, 8'h00));
      // Table writes at both index extremes; inbound pattern byte becomes zero
      pending_reqs.push_back(mk_req(REQ_TBL_WRITE, 1'b0, 8'hFF, 1'b1, 5'd31, 8'h00));
      pending_reqs.push_back(mk_req(REQ_TBL_WRITE, 1'b1, 8'h00, 1'b0, 5'd0, 8'hFF));
      gen_find[31] = 8'hFF;
      gen_find[MAX_PATTERN] = 8'h00;
      wait_quiet();
      write_len(CSR_OUT_LEN, 6'd0);
      write_len(CSR_IN_LEN, 6'd1);
      // Zero byte pattern: first hit replaced, second left alone
      pending_reqs.push_back(mk_req(REQ_PAYLOAD, 1'b1, 8'h00, 1'b0, 5'd0, 8'h00));
      pending_reqs.push_back(mk_req(REQ_PAYLOAD, 1'b1, 8'h00, 1'b0, 5'd0, 8'h00));
      wait_quiet();
      write_len(CSR_IN_LEN, 6'd63);   // clamps to the window size
      pending_reqs.push_back(mk_req(REQ_PAYLOAD, 1'b1, 8'h11, 1'b0, 5'd0, 8'h00));
      pending_reqs.push_back(mk_req(REQ_PAYLOAD, 1'b1, 8'h22, 1'b0, 5'd0, 8'h00));
      wait_quiet();
      write_len(CSR_IN_LEN, 6'd1);    // shrink with two bytes held
      pending_reqs.push_back(mk_req(REQ_PAYLOAD, 1'b1, 8'h33, 1'b0, 5'd0, 8'h00));
      pending_reqs.push_back(mk_req(REQ_PAYLOAD, 1'b0, 8'hFF, 1'b1, 5'd31, 8'hFF));

      // Random phases, each with its own lengths; the idle pattern repeats every four phases
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         wait_quiet();
         write_len(CSR_OUT_LEN, phase_out_len[ph]);
         write_len(CSR_IN_LEN, phase_in_len[ph]);
         case (ph % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_gap_pct = 56; rsp_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct = 56; end
            default: begin send_gap_pct = 36; rsp_stall_pct = 36; end
         endcase
         added = 0;
         while (added < 24) begin
            gen_packet(ph == 1 && added == 0, n);
            added += n;
         end
      end

      wait_quiet();
      repeat (END_WAIT) @(posedge clock);
      if (expected_bytes.size() != 0)
         report_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
